// ===== src/bfnb_pkg.sv =====
// ---------------------------------------------------------------------------
// Bitmap find-next-bit package
// Field widths, opcodes, default sizes and the types shared between the
// sequencer and the word scan unit.
// ---------------------------------------------------------------------------
package bfnb_pkg;

    // Default bitmap geometry
    localparam int BFNB_WORDS     = 16;
    localparam int BFNB_WORD_BITS = 64;

    // Payload field widths
    localparam int OPCODE_W = 2;
    localparam int WIDX_W   = 4;
    localparam int DATA_W   = 64;
    localparam int START_W  = 10;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;

    // Reset value of the bit count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FIND_SET   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND_CLEAR = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE       = 2'd3;

    // Scan unit works on a word padded to this many bits
    localparam int PAD_BITS = 64;
    localparam int OFF_W    = 6;

    // Control handed to the scan unit for one word
    typedef struct packed {
        logic want_clear;
        logic first;
    } scan_ctl_t;

    // Scan unit answer: hit flag and bit offset inside the word
    typedef struct packed {
        logic             hit;
        logic [OFF_W-1:0] offset;
    } scan_res_t;

endpackage

// ===== src/bfnb_in_if.sv =====
// ---------------------------------------------------------------------------
// Bitmap find-next-bit request channel
// Valid/ready channel carrying one request word: opcode, word index,
// word data and search start bit.
// ---------------------------------------------------------------------------
interface bfnb_in_if;
    import bfnb_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [WIDX_W-1:0]   word_index;
    logic [DATA_W-1:0]   word_data;
    logic [START_W-1:0]  start_bit;

    modport source (
        output valid,
        output opcode,
        output word_index,
        output word_data,
        output start_bit,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  word_index,
        input  word_data,
        input  start_bit,
        output ready
    );
endinterface

// ===== src/bfnb_out_if.sv =====
// ---------------------------------------------------------------------------
// Bitmap find-next-bit result channel
// Valid/ready channel carrying one result word: found flag and bit index.
// ---------------------------------------------------------------------------
interface bfnb_out_if;
    import bfnb_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] bit_index;

    modport source (
        output valid,
        output found,
        output bit_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  bit_index,
        output ready
    );
endinterface

// ===== src/bfnb_mem.sv =====
// ---------------------------------------------------------------------------
// Bitmap word store
// One write port and one registered read port. After reset a clearing pass
// zeroes every word, one word per cycle, while busy is high.
// ---------------------------------------------------------------------------
module bfnb_mem #(
    parameter int WORDS     = bfnb_pkg::BFNB_WORDS,
    parameter int WORD_BITS = bfnb_pkg::BFNB_WORD_BITS,
    parameter int AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    output logic                 busy
);
    import bfnb_pkg::*;

    localparam int CNT_W = $clog2(WORDS + 1);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [CNT_W-1:0]     clr_cnt_reg;
    logic [CNT_W-1:0]     clr_cnt_next;
    logic                 clr_active_reg;
    logic                 clr_active_next;
    logic [AW-1:0]        clr_addr;

    assign clr_addr = clr_cnt_reg[AW-1:0];

    // Advance the clearing pass until the last word is zeroed
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            if (clr_cnt_reg == CNT_W'(WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clr_active_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            clr_active_reg <= clr_active_next;
        end
    end

    // Write port: clearing pass first, then item writes
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

// ===== src/bfnb_scan.sv =====
// ---------------------------------------------------------------------------
// Bitmap word scan unit
// Masks one stored word to the live window [start, count) and returns the
// lowest matching bit, for set or clear search.
// ---------------------------------------------------------------------------
module bfnb_scan #(
    parameter int WORD_BITS = bfnb_pkg::BFNB_WORD_BITS,
    parameter int POS_W     = 11
) (
    input  logic [WORD_BITS-1:0]  data,
    input  logic [POS_W-1:0]      base,
    input  logic [POS_W-1:0]      start,
    input  logic [POS_W-1:0]      count,
    input  bfnb_pkg::scan_ctl_t   ctl,
    output bfnb_pkg::scan_res_t   res
);
    import bfnb_pkg::*;

    logic [POS_W-1:0]     span;
    logic [POS_W-1:0]     lo;
    logic                 span_full;
    logic [WORD_BITS-1:0] top_mask;
    logic [WORD_BITS-1:0] bot_mask;
    logic [WORD_BITS-1:0] cand;

    // Binary search for the lowest set bit, one halving per step
    function automatic scan_res_t lowest_set(input logic [PAD_BITS-1:0] v);
        logic [PAD_BITS-1:0] x;
        scan_res_t           r;
        x        = v;
        r.hit    = |v;
        r.offset = '0;
        for (int k = OFF_W - 1; k >= 0; k--)
        begin
            if ((x & ((PAD_BITS'(1) << (1 << k)) - PAD_BITS'(1))) == '0)
            begin
                r.offset[k] = 1'b1;
                x           = x >> (1 << k);
            end
        end
        return r;
    endfunction

    // Window limits relative to this word
    assign span      = count - base;
    assign span_full = (32'(span) >= 32'(WORD_BITS));
    assign lo        = ctl.first ? (start - base) : '0;

    // Build the window masks bit by bit
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            top_mask[j] = span_full || (32'(j) < 32'(span));
            bot_mask[j] = (32'(j) >= 32'(lo));
        end
    end

    // Invert for clear search, drop bits outside the window
    assign cand = (data ^ {WORD_BITS{ctl.want_clear}}) & top_mask & bot_mask;
    assign res  = lowest_set(PAD_BITS'(cand));

endmodule

// ===== src/bitmap_find_next_bit_core.sv =====
// ---------------------------------------------------------------------------
// Bitmap find-next-bit core
// Keeps a bitmap of WORDS words of WORD_BITS bits and answers find-next-set
// and find-next-clear queries from a start bit, below a configured count.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : request words (opcode, word_index, word_data, start_bit),
//            valid/ready, taken when both are high.
//   out_ch : one result word per request (found, bit_index), valid/ready.
//   cfg_we / cfg_wdata : write of the bit count register, only while idle.
// Timing:
//   A write, unused opcode, or search that starts at or past the count
//   presents its result the cycle after acceptance.
//   A search first forms the start word, then reads it from the registered
//   read port; the shared scan unit then looks at one stored word per
//   cycle (1..WORDS words) until a hit, and a search that finds nothing
//   ends on a further scan step that sees the base past the count. One
//   request is in flight at a time.
// Reset:
//   The bit count returns to 1024 and a clearing pass zeroes the store
//   with in_ch.ready held low meanwhile.
// Stall:
//   A held result stays in the output register; a new request is taken
//   only once that register is free or being emptied in the same cycle.
// ---------------------------------------------------------------------------
module bitmap_find_next_bit_core #(
    parameter int WORDS     = bfnb_pkg::BFNB_WORDS,
    parameter int WORD_BITS = bfnb_pkg::BFNB_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bfnb_pkg::COUNT_W-1:0]  cfg_wdata,
    bfnb_in_if.sink                       in_ch,
    bfnb_out_if.source                    out_ch
);
    import bfnb_pkg::*;

    localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TOTAL_BITS = WORDS * WORD_BITS;
    localparam int POS_W      = $clog2(TOTAL_BITS + 1);
    // Start word by ceiling reciprocal; exact for 10-bit starts and
    // word widths up to 64
    localparam int DIV_SHIFT  = 16;
    localparam int RECIP      = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W     = START_W + DIV_SHIFT + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BASE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [AW-1:0]        word_reg, word_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic [POS_W-1:0]     start_reg, start_next;
    logic                 clear_reg, clear_next;
    logic                 first_reg, first_next;
    logic                 res_found_reg, res_found_next;
    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg;
    logic [INDEX_W-1:0]   out_index_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 out_load;
    logic                 out_load_found;
    logic [POS_W-1:0]     out_load_pos;
    logic                 mem_busy;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    logic [POS_W-1:0]     eff_count;
    logic                 is_search;
    logic                 start_live;
    logic [AW-1:0]        word_calc;
    scan_ctl_t            scan_ctl;
    scan_res_t            scan_res;

    // Clamp the count to the size of the store
    assign eff_count = (32'(count_reg) > TOTAL_BITS) ? POS_W'(TOTAL_BITS)
                                                     : POS_W'(count_reg);

    // Handshake
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !mem_busy && out_free;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign is_search  = (in_ch.opcode == OP_FIND_SET) || (in_ch.opcode == OP_FIND_CLEAR);
    assign start_live = (32'(in_ch.start_bit) < 32'(eff_count));
    assign mem_wr_en  = in_fire && (in_ch.opcode == OP_WRITE)
                        && (32'(in_ch.word_index) < WORDS);
    assign word_calc  = prod_reg[DIV_SHIFT +: AW];

    // Read the start word first, then the word after the one under test
    assign mem_rd_addr = (state_reg == S_BASE) ? word_calc : (word_reg + AW'(1));

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        word_next      = word_reg;
        base_next      = base_reg;
        start_next     = start_reg;
        clear_next     = clear_reg;
        first_next     = first_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        out_load       = 1'b0;
        out_load_found = 1'b0;
        out_load_pos   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_search && start_live)
                    begin
                        prod_next  = PROD_W'(in_ch.start_bit) * PROD_W'(RECIP);
                        start_next = POS_W'(in_ch.start_bit);
                        clear_next = (in_ch.opcode == OP_FIND_CLEAR);
                        state_next = S_BASE;
                    end
                    else
                    begin
                        // Writes, unused opcode and dead searches answer at once
                        out_load = 1'b1;
                    end
                end
            end
            S_BASE:
            begin
                word_next  = word_calc;
                base_next  = POS_W'(word_calc) * POS_W'(WORD_BITS);
                first_next = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (base_reg >= eff_count)
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = S_DONE;
                end
                else if (scan_res.hit)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = base_reg + POS_W'(scan_res.offset);
                    state_next     = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + AW'(1);
                    base_next  = base_reg + POS_W'(WORD_BITS);
                    first_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_load_found = res_found_reg;
                    out_load_pos   = res_pos_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers of the sequencer
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        word_reg      <= word_next;
        base_reg      <= base_next;
        start_reg     <= start_next;
        clear_reg     <= clear_next;
        first_reg     <= first_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
    end

    // Output register: hold until taken
    assign out_valid_next = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= out_load_found;
            out_index_reg <= INDEX_W'(out_load_pos);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.found     = out_found_reg;
    assign out_ch.bit_index = out_index_reg;

    // Word store
    bfnb_mem #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (AW'(in_ch.word_index)),
        .wr_data (in_ch.word_data[WORD_BITS-1:0]),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .busy    (mem_busy)
    );

    // Shared word scan unit
    assign scan_ctl.want_clear = clear_reg;
    assign scan_ctl.first      = first_reg;

    bfnb_scan #(
        .WORD_BITS (WORD_BITS),
        .POS_W     (POS_W)
    ) u_scan (
        .data  (mem_rd_data),
        .base  (base_reg),
        .start (start_reg),
        .count (eff_count),
        .ctl   (scan_ctl),
        .res   (scan_res)
    );

    // No request is taken during the clearing pass
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !in_ch.ready)
        else $error("request accepted during clearing pass");

    // No request is taken while a search is in progress
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("request accepted while searching");

    // A live hit ends the scan with a found result
    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && base_reg < eff_count && scan_res.hit)
        |=> (state_reg == S_DONE && res_found_reg))
        else $error("scan hit not recorded");

    // A found position lies inside the search window
    a_found_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_found_reg)
        |-> (res_pos_reg >= start_reg && res_pos_reg < eff_count))
        else $error("found bit outside search window");

endmodule

// ===== tb/bfnb_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// Bitmap find-next-bit result board
// Holds a private copy of the bitmap and the bit count, works out the answer
// to every accepted request word and checks returned result words in order.
// ---------------------------------------------------------------------------
package bfnb_tb_pkg;
    import bfnb_pkg::*;

    localparam int unsigned TOTAL_BITS = BFNB_WORDS * BFNB_WORD_BITS;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] bit_index;
    } answer_t;

    class bit_search_board;
        logic [DATA_W-1:0]  words [BFNB_WORDS];
        logic [COUNT_W-1:0] count_reg;
        answer_t            answers [$];
        int                 mismatches;

        function new();
            foreach (words[i])
                words[i] = '0;
            count_reg  = COUNT_RESET;
            mismatches = 0;
        endfunction

        // Ones in the n lowest positions, n up to a whole word
        function logic [DATA_W-1:0] low_mask(input int unsigned n);
            if (n >= BFNB_WORD_BITS)
                return '1;
            return (DATA_W'(1) << n) - DATA_W'(1);
        endfunction

        function void set_count(input logic [COUNT_W-1:0] value);
            count_reg = value;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        // Apply one accepted request word and queue the answer it must give
        function void note_request(input logic [OPCODE_W-1:0] op,
                                   input logic [WIDX_W-1:0]   widx,
                                   input logic [DATA_W-1:0]   data,
                                   input logic [START_W-1:0]  start);
            answer_t           ans;
            int unsigned       limit;
            int unsigned       first_w;
            int unsigned       base;
            int unsigned       pos;
            logic [DATA_W-1:0] v;

            ans = '0;
            if (op == OP_WRITE)
            begin
                if (int'(widx) < BFNB_WORDS)
                    words[widx] = data;
            end
            else if (op == OP_FIND_SET || op == OP_FIND_CLEAR)
            begin
                // Clamp the count to the store size
                limit   = (count_reg > TOTAL_BITS) ? TOTAL_BITS : count_reg;
                first_w = start / BFNB_WORD_BITS;
                if (start < limit)
                begin
                    // Scan upward word by word, masking the tail and the head
                    for (int w = first_w; w < BFNB_WORDS && !ans.found; w++)
                    begin
                        base = w * BFNB_WORD_BITS;
                        if (base >= limit)
                            break;
                        v = words[w];
                        if (op == OP_FIND_CLEAR)
                            v = ~v;
                        if (limit - base < BFNB_WORD_BITS)
                            v &= low_mask(limit - base);
                        if (w == first_w)
                            v &= ~low_mask(start - base);
                        if (v != '0)
                        begin
                            pos = 0;
                            while (!v[pos])
                                pos++;
                            ans.found     = 1'b1;
                            ans.bit_index = INDEX_W'(base + pos);
                        end
                    end
                end
            end
            answers.push_back(ans);
        endfunction

        // Compare one accepted result word with the oldest queued answer
        function void check_answer(input logic found, input logic [INDEX_W-1:0] bit_index);
            answer_t want;

            if (answers.size() == 0)
            begin
                $display("%0t: result word with no request waiting, found %0d bit_index %0d",
                         $time, found, bit_index);
                mismatches++;
                return;
            end
            want = answers.pop_front();
            if (found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0d actual %0d",
                         $time, want.found, found);
                mismatches++;
            end
            if (bit_index !== want.bit_index)
            begin
                $display("%0t: bit_index mismatch, expected %0d actual %0d",
                         $time, want.bit_index, bit_index);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Bitmap find-next-bit core testbench
// Drives word writes and set/clear searches under a series of bit counts,
// with random gaps on both channels, and checks every result word against
// answers worked out from a private copy of the bitmap.
// ---------------------------------------------------------------------------
module tb_top;
    import bfnb_pkg::*;
    import bfnb_tb_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_WORDS = 65;

    logic               clk       = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    logic               send_calm = 1'b0;
    logic               take_calm = 1'b0;
    int                 idle_cycles;

    bfnb_in_if  req_ch ();
    bfnb_out_if ans_ch ();

    bit_search_board board;

    bitmap_find_next_bit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req_ch),
        .out_ch    (ans_ch)
    );

    // Free-running clock, period 20
    always #10 clk = ~clk;

    // Offer one request word after a random gap and hold it until taken
    task automatic drive_request(input logic [OPCODE_W-1:0] op,
                                 input logic [WIDX_W-1:0]   widx,
                                 input logic [DATA_W-1:0]   data,
                                 input logic [START_W-1:0]  start);
        int gap;

        gap = send_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.word_index <= widx;
        req_ch.word_data  <= data;
        req_ch.start_bit  <= start;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(op, widx, data, start);
    endtask

    // Drop valid and hold until every queued answer has come back
    task automatic wait_for_answers();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Write the bit count register; only called while the core is idle
    task automatic write_count(input logic [COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_count(value);
    endtask

    // Result side: random stalls, then take and check one word
    initial
    begin : take_answers
        int gap;

        ans_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = take_calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                ans_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            ans_ch.ready <= 1'b1;
            @(posedge clk);
            while (!ans_ch.valid)
                @(posedge clk);
            board.check_answer(ans_ch.found, ans_ch.bit_index);
        end
    end

    // End the run when nothing moves on either channel for too long
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (ans_ch.valid && ans_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : run_stimulus
        logic [COUNT_W-1:0]  counts [NUM_PHASES];
        logic [OPCODE_W-1:0] op;
        logic [DATA_W-1:0]   data;
        logic [START_W-1:0]  start;
        int                  pick;

        board = new();
        counts = '{11'd1, 11'd0, 11'd2047, 11'd64, 11'd65,
                   11'd1023, 11'd1024, 11'd130, 11'd1, 11'd1000};
        counts[8] = COUNT_W'($urandom_range(1, 1024));

        // Known values on every input while reset is held, then release it
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_WRITE;
        req_ch.word_index <= '0;
        req_ch.word_data  <= '0;
        req_ch.start_bit  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty bitmap at full count: nothing set, everything clear
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd0);
        drive_request(OP_FIND_CLEAR, 4'd0,  '0, 10'd0);
        drive_request(OP_FIND_CLEAR, 4'd0,  '0, 10'd1023);
        drive_request(OP_NONE,       4'd15, '1, 10'd1023);
        // Longest scan to the top word, then extremes of data and start
        drive_request(OP_WRITE,      4'd15, '1, 10'd0);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd0);
        drive_request(OP_FIND_CLEAR, 4'd0,  '0, 10'd960);
        drive_request(OP_WRITE,      4'd0,  '1, 10'd0);
        drive_request(OP_WRITE,      4'd7,  64'h8000_0000_0000_0000, 10'd0);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd1);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd64);
        drive_request(OP_FIND_CLEAR, 4'd0,  '0, 10'd0);
        drive_request(OP_WRITE,      4'd15, 64'h8000_0000_0000_0000, 10'd0);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd1023);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd512);
        drive_request(OP_WRITE,      4'd0,  '0, 10'd0);
        drive_request(OP_FIND_CLEAR, 4'd0,  '0, 10'd511);

        // Count inside a word: tail bits masked, start on the last live bit and at the count
        wait_for_answers();
        write_count(11'd70);
        drive_request(OP_WRITE,      4'd1,  '1, 10'd0);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd64);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd69);
        drive_request(OP_FIND_SET,   4'd0,  '0, 10'd70);
        drive_request(OP_FIND_CLEAR, 4'd0,  '0, 10'd64);

        // Random traffic under each bit count
        foreach (counts[ph])
        begin
            wait_for_answers();
            write_count(counts[ph]);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // Switch between gappy and back-to-back stretches
                if (i % 20 == 0)
                begin
                    send_calm = ($urandom_range(0, 3) == 0);
                    take_calm = ($urandom_range(0, 3) == 0);
                end
                if (i == 30 || $urandom_range(0, 49) == 0)
                    wait_for_answers();

                pick = $urandom_range(0, 99);
                if (pick < 35)
                    op = OP_WRITE;
                else if (pick < 65)
                    op = OP_FIND_SET;
                else if (pick < 95)
                    op = OP_FIND_CLEAR;
                else
                    op = OP_NONE;

                // Mostly empty, full, single-bit or sparse words for long scans
                case ($urandom_range(0, 5))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = DATA_W'(1) << $urandom_range(0, 63);
                    3:       data = ~(DATA_W'(1) << $urandom_range(0, 63));
                    4:       data = {$urandom, $urandom};
                    default: data = {$urandom, $urandom} & {$urandom, $urandom}
                                    & {$urandom, $urandom};
                endcase

                // Start anywhere, around the count, or on a word edge
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    start = START_W'($urandom_range(0, 1023));
                else if (pick < 8)
                    start = START_W'(board.count_reg + 1 - $urandom_range(0, 2));
                else
                    start = START_W'($urandom_range(0, 15) * BFNB_WORD_BITS
                                     + ($urandom_range(0, 1) * (BFNB_WORD_BITS - 1)));

                drive_request(op, WIDX_W'($urandom_range(0, 15)), data, start);
            end
        end

        // Drain, then allow a late stray result to show up
        wait_for_answers();
        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
